[hdl/assert_macros.svh]
// Assertion helpers shared by the block's RTL files.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define TKK_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tkk assertion failed");

// The trigger at one edge implies the consequence at the same edge.
`define TKK_ASSERT_SAME(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("tkk assertion failed");

// The trigger at one edge implies the consequence at the next edge.
`define TKK_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("tkk assertion failed");

`endif

[hdl/tkk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K target keeper package
// Shared entry type, control struct, the ID_NONE constant and the ranking function.
// ----------------------------------------------------------------------------
package tkk_pkg;

  localparam logic [31:0] ID_NONE = 32'd0;

  typedef struct packed {
    logic [31:0] body;
    logic [31:0] actor;
    logic [31:0] rank;
  } entry_t;

  typedef struct packed {
    logic take;
    logic flush;
  } ctl_t;

  // True when entry a ranks strictly lower than entry b. Actors outrank non-actors.
  function automatic logic ranks_lower(entry_t a, entry_t b);
    logic a_is;
    logic b_is;
    a_is = (a.actor != ID_NONE);
    b_is = (b.actor != ID_NONE);
    if (a_is != b_is) begin
      return b_is;
    end
    return (a.rank < b.rank);
  endfunction

endpackage

[hdl/tkk_cand_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Candidate channel
// Valid/ready channel that carries one candidate request.
// ----------------------------------------------------------------------------
interface tkk_cand_if;
  logic        valid;
  logic        ready;
  logic [31:0] body_id;
  logic [31:0] actor_id;
  logic [31:0] rank_value;
  logic        final_candidate;

  modport source (output valid, output body_id, output actor_id, output rank_value,
                  output final_candidate, input ready);
  modport sink (input valid, input body_id, input actor_id, input rank_value,
                input final_candidate, output ready);
endinterface

[hdl/tkk_kept_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kept entry channel
// Valid/ready channel that carries one emitted list entry.
// ----------------------------------------------------------------------------
interface tkk_kept_if;
  logic        valid;
  logic        ready;
  logic [31:0] kept_body_id;
  logic [31:0] kept_actor_id;
  logic [31:0] kept_rank;
  logic        end_of_list;

  modport source (output valid, output kept_body_id, output kept_actor_id,
                  output kept_rank, output end_of_list, input ready);
  modport sink (input valid, input kept_body_id, input kept_actor_id,
                input kept_rank, input end_of_list, output ready);
endinterface

[hdl/tkk_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K insertion list
// Holds the sorted kept entries and inserts one candidate per cycle while ctl.take is set.
// ----------------------------------------------------------------------------
module tkk_insert
  import tkk_pkg::*;
#(
  parameter int KEEP_DEPTH = 4,
  localparam int CW = $clog2(KEEP_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  input  entry_t        cand,
  output entry_t        list_next [KEEP_DEPTH],
  output logic [CW-1:0] count_next
);

  entry_t                slot [KEEP_DEPTH];
  logic [CW-1:0]         count;
  logic [KEEP_DEPTH-1:0] lower;
  logic [KEEP_DEPTH-1:0] lower_prev;
  logic [KEEP_DEPTH-1:0] hit;
  logic                  insert_ok;

  always_comb begin
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (CW'(i) < count) begin
        lower[i] = ranks_lower(slot[i], cand);
        hit[i]   = ((cand.body != ID_NONE) && (slot[i].body == cand.body)) ||
                   ((cand.actor != ID_NONE) && (slot[i].actor == cand.actor));
      end else begin
        lower[i] = 1'b1;
        hit[i]   = 1'b0;
      end
    end
    lower_prev[0] = 1'b0;
    for (int i = 1; i < KEEP_DEPTH; i++) begin
      lower_prev[i] = lower[i-1];
    end
    insert_ok = !(|hit) && (|lower);
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (!insert_ok || !lower[i]) begin
        list_next[i] = slot[i];
      end else if (!lower_prev[i]) begin
        list_next[i] = cand;
      end else begin
        list_next[i] = slot[(i > 0) ? i - 1 : 0];
      end
    end
    if (insert_ok && (count < CW'(KEEP_DEPTH))) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      slot <= list_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.take) begin
      count <= ctl.flush ? '0 : count_next;
    end
  end

  `include "assert_macros.svh"

  `TKK_ASSERT_ALWAYS(a_count_bound, count <= CW'(KEEP_DEPTH))
  `TKK_ASSERT_NEXT(a_flush_clears, ctl.take && ctl.flush, count == '0)
  `TKK_ASSERT_NEXT(a_count_grows, ctl.take && !ctl.flush, count >= $past(count))

endmodule

[hdl/tkk_drain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K list drain
// Captures a finished list and emits it best first through an output register.
// ----------------------------------------------------------------------------
module tkk_drain
  import tkk_pkg::*;
#(
  parameter int KEEP_DEPTH = 4,
  localparam int CW = $clog2(KEEP_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  entry_t        list_in [KEEP_DEPTH],
  input  logic [CW-1:0] count_in,
  output logic          idle,
  tkk_kept_if.source    kept
);

  entry_t        pend [KEEP_DEPTH];
  logic [CW-1:0] pend_count;
  logic          emit;
  entry_t        out_entry;
  logic          out_last;

  assign idle = (pend_count == '0);
  assign emit = !idle && (!kept.valid || kept.ready);

  always_ff @(posedge clk) begin
    if (load) begin
      pend <= list_in;
    end else if (emit) begin
      for (int i = 0; i < KEEP_DEPTH - 1; i++) begin
        pend[i] <= pend[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_entry <= pend[0];
      out_last  <= (pend_count == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      kept.valid <= 1'b0;
    end else begin
      if (load) begin
        pend_count <= count_in;
      end else if (emit) begin
        pend_count <= pend_count - CW'(1);
      end
      if (emit) begin
        kept.valid <= 1'b1;
      end else if (kept.ready) begin
        kept.valid <= 1'b0;
      end
    end
  end

  assign kept.kept_body_id  = out_entry.body;
  assign kept.kept_actor_id = out_entry.actor;
  assign kept.kept_rank     = out_entry.rank;
  assign kept.end_of_list   = out_last;

  `include "assert_macros.svh"

  `TKK_ASSERT_NEXT(a_last_drained, emit && (pend_count == CW'(1)), kept.valid && kept.end_of_list)
  `TKK_ASSERT_SAME(a_more_follows, kept.valid && !kept.end_of_list, pend_count != '0)
  `TKK_ASSERT_NEXT(a_hold_stall, kept.valid && !kept.ready, kept.valid && $stable(kept.kept_body_id))

endmodule

[hdl/top_k_target_keeper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K target keeper
// Keeps the best KEEP_DEPTH candidates of a set and emits them best first.
// ----------------------------------------------------------------------------
// Candidates arrive on cand, one request per cycle while cand.ready is high.
// Each is captured in an input register and compared against every kept
// entry at once: duplicates are ignored and others are inserted in rank
// order, the lowest entry falling out when the list is full. The list updates
// at one candidate per cycle unless a final request waits. A request with
// final_candidate set is inserted as well, then the whole list moves into a
// drain buffer and the store starts empty again. The drain buffer sends one
// entry per cycle on kept while kept.ready holds, end_of_list marking the
// last; the first entry reaches kept through the drain buffer and the output
// register. A final request waits in the input register while an earlier
// list still drains. A stall on kept holds the output register and stops the
// drain; cand keeps flowing until the next final request. Reset empties the
// list, the drain buffer and the output register.
// ----------------------------------------------------------------------------
module top_k_target_keeper
  import tkk_pkg::*;
#(
  parameter int KEEP_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  tkk_cand_if.sink   cand,
  tkk_kept_if.source kept
);

  localparam int CW = $clog2(KEEP_DEPTH + 1);

  logic          held_valid;
  entry_t        held_entry;
  logic          held_final;
  logic          advance;
  logic          drain_idle;
  ctl_t          ctl;
  entry_t        list_next [KEEP_DEPTH];
  logic [CW-1:0] count_next;

  assign advance    = held_valid && (!held_final || drain_idle);
  assign cand.ready = !held_valid || advance;
  assign ctl.take   = advance;
  assign ctl.flush  = held_final;

  always_ff @(posedge clk) begin
    if (cand.valid && cand.ready) begin
      held_entry.body  <= cand.body_id;
      held_entry.actor <= cand.actor_id;
      held_entry.rank  <= cand.rank_value;
      held_final       <= cand.final_candidate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cand.ready) begin
      held_valid <= cand.valid;
    end
  end

  tkk_insert #(
    .KEEP_DEPTH(KEEP_DEPTH)
  ) u_insert (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cand       (held_entry),
    .list_next  (list_next),
    .count_next (count_next)
  );

  tkk_drain #(
    .KEEP_DEPTH(KEEP_DEPTH)
  ) u_drain (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && held_final),
    .list_in  (list_next),
    .count_in (count_next),
    .idle     (drain_idle),
    .kept     (kept)
  );

endmodule

[dv/top_k_target_keeper_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K target keeper testbench
// Drives candidate requests in sets closed by a final request, keeps a
// four-entry ranked list of its own and checks every emitted kept entry in
// order. Directed sets cover the field extremes, ties, zero ids, duplicates
// and dropped candidates. Random sets follow, with idle bursts on both sides
// and one long output stall that backs the block up to its input.
// ----------------------------------------------------------------------------
module top_k_target_keeper_tb;
  import tkk_pkg::*;

  localparam int KEEP = 4;
  localparam int RANDOM_REQUESTS = 240;
  localparam int CALM_AFTER = 190;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    entry_t ent;
    logic   last;
  } kept_result_t;

  class keeper_scoreboard;
    entry_t         slot_q[KEEP];
    int unsigned    held;
    kept_result_t   expected_q[$];
    int unsigned    mismatches;
    int unsigned    results_seen;
    int unsigned    requests_seen;
    int unsigned    lists_seen;

    function new();
      clear_list();
    endfunction

    function void clear_list();
      for (int i = 0; i < KEEP; i++) begin
        slot_q[i] = '0;
      end
      held = 0;
    endfunction

    function bit outranks(entry_t a, entry_t b);
      bit a_actor;
      bit b_actor;
      a_actor = (a.actor != ID_NONE);
      b_actor = (b.actor != ID_NONE);
      if (a_actor != b_actor) begin
        return a_actor;
      end
      return (a.rank > b.rank);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(entry_t c, logic fin);
      int pos;
      bit dup;
      requests_seen++;
      dup = 0;
      for (int i = 0; i < held; i++) begin
        if ((c.body != ID_NONE && slot_q[i].body == c.body) ||
            (c.actor != ID_NONE && slot_q[i].actor == c.actor)) begin
          dup = 1;
        end
      end
      if (!dup) begin
        pos = 0;
        while (pos < held && !outranks(c, slot_q[pos])) begin
          pos++;
        end
        if (pos < KEEP) begin
          for (int i = KEEP - 1; i > pos; i--) begin
            slot_q[i] = slot_q[i - 1];
          end
          slot_q[pos] = c;
          if (held < KEEP) begin
            held++;
          end
        end
      end
      if (fin) begin
        for (int i = 0; i < held; i++) begin
          expected_q.push_back('{ent: slot_q[i], last: (i == held - 1)});
        end
        lists_seen++;
        clear_list();
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_entry(kept_result_t got);
      kept_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected kept entry body=%h actor=%h rank=%h",
                                got.ent.body, got.ent.actor, got.ent.rank));
      end else begin
        want = expected_q.pop_front();
        if (got.ent.body !== want.ent.body) begin
          flag_mismatch($sformatf("kept_body_id %h, expected %h", got.ent.body, want.ent.body));
        end
        if (got.ent.actor !== want.ent.actor) begin
          flag_mismatch($sformatf("kept_actor_id %h, expected %h",
                                  got.ent.actor, want.ent.actor));
        end
        if (got.ent.rank !== want.ent.rank) begin
          flag_mismatch($sformatf("kept_rank %h, expected %h", got.ent.rank, want.ent.rank));
        end
        if (got.last !== want.last) begin
          flag_mismatch($sformatf("end_of_list %b, expected %b", got.last, want.last));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  tkk_cand_if cand();
  tkk_kept_if kept();

  keeper_scoreboard sb = new();
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 0;
  bit calm = 0;
  bit held_off = 0;

  top_k_target_keeper #(.KEEP_DEPTH(KEEP)) dut (
    .clk (clk),
    .rst (rst),
    .cand(cand),
    .kept(kept)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if ((cand.valid && cand.ready) || (kept.valid && kept.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (cand.valid && cand.ready) begin
        sb.note_request('{body: cand.body_id, actor: cand.actor_id, rank: cand.rank_value},
                        cand.final_candidate);
      end
      if (kept.valid && kept.ready) begin
        sb.check_entry('{ent: '{body: kept.kept_body_id, actor: kept.kept_actor_id,
                                rank: kept.kept_rank},
                         last: kept.end_of_list});
      end
    end
  end

  task send_candidate(logic [31:0] body, logic [31:0] actor, logic [31:0] rank, logic fin);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      cand.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cand.valid           <= 1'b1;
    cand.body_id         <= body;
    cand.actor_id        <= actor;
    cand.rank_value      <= rank;
    cand.final_candidate <= fin;
    do @(posedge clk); while (!cand.ready);
  endtask

  function automatic entry_t random_candidate();
    entry_t c;
    case ($urandom_range(0, 9))
      0:          c.body = ID_NONE;
      1, 2, 3, 4: c.body = $urandom_range(1, 12);
      5:          c.body = 32'hFFFF_FFFF;
      default:    c.body = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c.actor = ID_NONE;
      4, 5, 6:    c.actor = $urandom_range(1, 8);
      7:          c.actor = 32'hFFFF_FFFF;
      default:    c.actor = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       c.rank = 32'd0;
      1:       c.rank = 32'hFFFF_FFFF;
      2, 3, 4: c.rank = {14'd0, 2'($urandom_range(0, 3)), 16'd0};
      default: c.rank = $urandom;
    endcase
    return c;
  endfunction

  initial begin
    kept.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (!held_off && sb.results_seen >= 12) begin
        held_off = 1;
        kept.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        kept.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        kept.ready <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        kept.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned set_len;
    entry_t c;
    rst                  <= 1'b1;
    cand.valid           <= 1'b0;
    cand.body_id         <= '0;
    cand.actor_id        <= '0;
    cand.rank_value      <= '0;
    cand.final_candidate <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 0;
    send_candidate(32'd1, ID_NONE, 32'd100, 1'b0);
    send_candidate(32'd2, ID_NONE, 32'd100, 1'b0);
    send_candidate(ID_NONE, ID_NONE, 32'd0, 1'b0);
    send_candidate(ID_NONE, ID_NONE, 32'd0, 1'b0);
    send_candidate(32'd3, ID_NONE, 32'd50, 1'b0);
    send_candidate(32'd4, ID_NONE, 32'd0, 1'b0);
    send_candidate(32'd1, ID_NONE, 32'd999, 1'b0);
    send_candidate(32'd5, 32'd7, 32'd0, 1'b0);
    send_candidate(32'd6, 32'd7, 32'hFFFF_FFFF, 1'b0);
    send_candidate(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_candidate(ID_NONE, ID_NONE, 32'd0, 1'b1);
    gap_pct = 30;
    send_candidate(32'd10, 32'd1, 32'hFFFF_FFFF, 1'b0);
    send_candidate(32'd11, 32'd2, 32'hFFFF_FFFF, 1'b0);
    send_candidate(32'd12, 32'd3, 32'd0, 1'b0);
    send_candidate(32'd13, ID_NONE, 32'hFFFF_FFFF, 1'b0);
    send_candidate(32'd14, 32'd4, 32'h8000_0000, 1'b0);
    send_candidate(32'd15, 32'd5, 32'd1, 1'b1);
    send_candidate(32'd20, ID_NONE, 32'h0001_0000, 1'b0);
    send_candidate(32'd20, 32'd9, 32'hFFFF_FFFF, 1'b0);
    send_candidate(32'd21, ID_NONE, 32'h0001_0000, 1'b1);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int k = 0; k < set_len; k++) begin
        c = random_candidate();
        send_candidate(c.body, c.actor, c.rank, k == set_len - 1);
        sent++;
        if (sent >= CALM_AFTER) begin
          calm = 1;
        end
      end
    end
    cand.valid <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d candidate requests forming %0d lists, including one long output stall.",
             sb.requests_seen, sb.lists_seen);
    $display("Checked %0d kept entries; %0d mismatches.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
